FILE: rtl/core/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and codes for the LRU buffer cache directory core.
// ----------------------------------------------------------------------------
package lbc_pkg;

   // default number of directory entries
   localparam int NUM_ENTRIES_DEF = 32;

   // request codes
   localparam logic [2:0] REQ_GET     = 3'd0;
   localparam logic [2:0] REQ_FILL    = 3'd1;
   localparam logic [2:0] REQ_RELEASE = 3'd2;
   localparam logic [2:0] REQ_PIN     = 3'd3;
   localparam logic [2:0] REQ_UNPIN   = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NOFREE = 2'd1;
   localparam logic [1:0] STAT_COUNT  = 2'd2;

   // reference count ceiling
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_PICK,
      S_COMMIT
   } lbc_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic search;
      logic pick;
      logic commit;
   } lbc_cmd_type;

endpackage

FILE: rtl/core/lbc_min_tree.sv
// ----------------------------------------------------------------------------
// lbc_min_tree
// Binary reduction tree that returns the candidate with the smallest key.
// ----------------------------------------------------------------------------
module lbc_min_tree import lbc_pkg::*; #(
   parameter int N  = NUM_ENTRIES_DEF,
   parameter int KW = $clog2(NUM_ENTRIES_DEF)
) (
   input  logic [N-1:0]         cand,
   input  logic [KW-1:0]        key [N],
   output logic                 found,
   output logic [$clog2(N)-1:0] index
);

   localparam int LV = $clog2(N);
   localparam int P  = 1 << LV;
   localparam int IW = $clog2(N);

   logic [P-1:0]  node_vld [LV+1];
   logic [KW-1:0] node_key [LV+1][P];
   logic [IW-1:0] node_idx [LV+1][P];

   // load leaves, pad the unused ones as empty
   for (genvar i = 0; i < P; i++) begin : g_leaf
      if (i < N) begin : g_real
         assign node_vld[0][i] = cand[i];
         assign node_key[0][i] = key[i];
         assign node_idx[0][i] = IW'(i);
      end else begin : g_pad
         assign node_vld[0][i] = 1'b0;
         assign node_key[0][i] = '0;
         assign node_idx[0][i] = '0;
      end
   end

   // reduce pairwise, keep the smaller valid key
   for (genvar l = 0; l < LV; l++) begin : g_lvl
      for (genvar j = 0; j < P; j++) begin : g_node
         if (j < (P >> (l + 1))) begin : g_live
            logic take_b;
            assign take_b = node_vld[l][2*j+1] &&
                            (!node_vld[l][2*j] ||
                             (node_key[l][2*j+1] < node_key[l][2*j]));
            assign node_vld[l+1][j] = node_vld[l][2*j] | node_vld[l][2*j+1];
            assign node_key[l+1][j] = take_b ? node_key[l][2*j+1] : node_key[l][2*j];
            assign node_idx[l+1][j] = take_b ? node_idx[l][2*j+1] : node_idx[l][2*j];
         end else begin : g_idle
            assign node_vld[l+1][j] = 1'b0;
            assign node_key[l+1][j] = '0;
            assign node_idx[l+1][j] = '0;
         end
      end
   end

   assign found = node_vld[LV][0];
   assign index = node_idx[LV][0];

endmodule

FILE: rtl/core/lbc_ctrl.sv
// ----------------------------------------------------------------------------
// lbc_ctrl
// Request sequencer: load, search, pick and commit one request at a time.
// ----------------------------------------------------------------------------
module lbc_ctrl import lbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output lbc_cmd_type cmd
);

   lbc_state_type state_ff;
   lbc_state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_SEARCH;
         end
         S_SEARCH: state_in = S_PICK;
         S_PICK:   state_in = S_COMMIT;
         S_COMMIT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_SEARCH: cmd.search = 1'b1;
         S_PICK:   cmd.pick   = 1'b1;
         S_COMMIT: cmd.commit = 1'b1;
         default:  cmd = '0;
      endcase
   end

   // an accepted word always enters the search step
   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_SEARCH))
      else $error("accepted word did not enter search");

   // commit follows pick, pick follows search
   a_pick_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |=> cmd.commit)
      else $error("pick not followed by commit");

   a_search_pick: assert property (@(posedge clock) disable iff (reset)
      cmd.search |=> cmd.pick)
      else $error("search not followed by pick");

   // at most one command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.search, cmd.pick, cmd.commit}))
      else $error("overlapping commands");

endmodule

FILE: rtl/core/lbc_datapath.sv
// ----------------------------------------------------------------------------
// lbc_datapath
// Directory storage, tag compare, LRU pick and entry update.
// ----------------------------------------------------------------------------
module lbc_datapath import lbc_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  lbc_cmd_type cmd,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_device,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_entry_index,
   output logic        rsp_valid,
   output logic [4:0]  rsp_result_index,
   output logic        rsp_hit,
   output logic        rsp_need_read,
   output logic [7:0]  rsp_refcount_now,
   output logic [1:0]  rsp_status
);

   localparam int IW = $clog2(NUM_ENTRIES);
   localparam int AW = (IW > 5) ? IW : 5;

   // directory state
   logic [7:0]             tag_dev_ff [NUM_ENTRIES];
   logic [31:0]            tag_blk_ff [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [7:0]             count_ff   [NUM_ENTRIES];
   logic [IW-1:0]          rank_ff    [NUM_ENTRIES];

   // request word
   logic [2:0]  type_ff;
   logic [7:0]  dev_ff;
   logic [31:0] blk_ff;
   logic [4:0]  idx_ff;

   // search and pick stages
   logic [NUM_ENTRIES-1:0] cand_ff;
   logic [IW-1:0]          key_ff [NUM_ENTRIES];
   logic                   hit_ff;
   logic                   pick_found_ff;
   logic [IW-1:0]          pick_idx_ff;

   // result registers
   logic       rsp_valid_ff;
   logic [4:0] rsp_idx_ff;
   logic       rsp_hit_ff;
   logic       rsp_rd_ff;
   logic [7:0] rsp_cnt_ff;
   logic [1:0] rsp_st_ff;

   logic [NUM_ENTRIES-1:0] match;
   logic [NUM_ENTRIES-1:0] free;
   logic                   any_match;
   logic                   tree_found;
   logic [IW-1:0]          tree_idx;

   logic [AW-1:0] idx_ext;
   logic [AW-1:0] tgt_ext;
   logic [IW-1:0] tgt;
   logic          in_range;
   logic [7:0]    cur_cnt;
   logic          cur_valid;
   logic [IW-1:0] tgt_rank;

   logic          wr_tag;
   logic          wr_valid;
   logic          valid_val;
   logic          wr_count;
   logic [7:0]    count_val;
   logic          move_rank;
   logic [4:0]    r_idx;
   logic          r_hit;
   logic          r_rd;
   logic [7:0]    r_cnt;
   logic [1:0]    r_st;

   // capture request word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         dev_ff  <= req_device;
         blk_ff  <= req_block_number;
         idx_ff  <= req_entry_index;
      end
   end

   // compare tags and find free entries
   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         match[i] = (tag_dev_ff[i] == dev_ff) && (tag_blk_ff[i] == blk_ff);
         free[i]  = (count_ff[i] == 8'd0);
      end
   end

   assign any_match = |match;

   // hold candidates: most recent match, else least recent free entry
   always_ff @(posedge clock) begin
      if (cmd.search) begin
         hit_ff  <= any_match;
         cand_ff <= any_match ? match : free;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            key_ff[i] <= any_match ? rank_ff[i] : ~rank_ff[i];
         end
      end
   end

   lbc_min_tree #(
      .N  (NUM_ENTRIES),
      .KW (IW)
   ) u_tree (
      .cand  (cand_ff),
      .key   (key_ff),
      .found (tree_found),
      .index (tree_idx)
   );

   // hold pick result
   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         pick_found_ff <= tree_found;
         pick_idx_ff   <= tree_idx;
      end
   end

   // select target entry
   assign idx_ext   = AW'(idx_ff);
   assign in_range  = (32'(idx_ff) < 32'(NUM_ENTRIES));
   assign tgt       = (type_ff == REQ_GET) ? pick_idx_ff : idx_ext[IW-1:0];
   assign tgt_ext   = AW'(tgt);
   assign cur_cnt   = count_ff[tgt];
   assign cur_valid = valid_ff[tgt];
   assign tgt_rank  = rank_ff[tgt];

   // decide update and result
   always_comb begin
      wr_tag    = 1'b0;
      wr_valid  = 1'b0;
      valid_val = 1'b0;
      wr_count  = 1'b0;
      count_val = cur_cnt;
      move_rank = 1'b0;
      r_idx     = '0;
      r_hit     = 1'b0;
      r_rd      = 1'b0;
      r_cnt     = '0;
      r_st      = STAT_OK;
      priority if (type_ff == REQ_GET) begin
         priority if (!pick_found_ff) begin
            r_st = STAT_NOFREE;
         end else if (hit_ff) begin
            r_idx = tgt_ext[4:0];
            r_hit = 1'b1;
            r_rd  = !cur_valid;
            if (cur_cnt == COUNT_MAX) begin
               r_st  = STAT_COUNT;
               r_cnt = cur_cnt;
            end else begin
               wr_count  = 1'b1;
               count_val = cur_cnt + 8'd1;
               r_cnt     = count_val;
            end
         end else begin
            wr_tag    = 1'b1;
            wr_valid  = 1'b1;
            valid_val = 1'b0;
            wr_count  = 1'b1;
            count_val = 8'd1;
            r_idx     = tgt_ext[4:0];
            r_rd      = 1'b1;
            r_cnt     = 8'd1;
         end
      end else if (type_ff > REQ_UNPIN) begin
         r_st = STAT_OK;
      end else if (!in_range) begin
         r_idx = idx_ff;
      end else begin
         r_idx = tgt_ext[4:0];
         unique case (type_ff)
            REQ_FILL: begin
               wr_valid  = 1'b1;
               valid_val = 1'b1;
               r_cnt     = cur_cnt;
            end
            REQ_PIN: begin
               if (cur_cnt == COUNT_MAX) begin
                  r_st  = STAT_COUNT;
                  r_cnt = cur_cnt;
               end else begin
                  wr_count  = 1'b1;
                  count_val = cur_cnt + 8'd1;
                  r_cnt     = count_val;
               end
            end
            default: begin
               // release and unpin
               if (cur_cnt == 8'd0) begin
                  r_st  = STAT_COUNT;
                  r_cnt = cur_cnt;
               end else begin
                  wr_count  = 1'b1;
                  count_val = cur_cnt - 8'd1;
                  r_cnt     = count_val;
                  move_rank = (type_ff == REQ_RELEASE) && (cur_cnt == 8'd1);
               end
            end
         endcase
      end
   end

   // update directory
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            tag_dev_ff[i] <= '0;
            tag_blk_ff[i] <= '0;
            count_ff[i]   <= '0;
            rank_ff[i]    <= IW'(NUM_ENTRIES - 1 - i);
         end
      end else if (cmd.commit) begin
         if (wr_tag) begin
            tag_dev_ff[tgt] <= dev_ff;
            tag_blk_ff[tgt] <= blk_ff;
         end
         if (wr_valid) valid_ff[tgt] <= valid_val;
         if (wr_count) count_ff[tgt] <= count_val;
         if (move_rank) begin
            // move target to most recent, age the more recent ones
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               if (tgt == IW'(i)) begin
                  rank_ff[i] <= '0;
               end else if (rank_ff[i] < tgt_rank) begin
                  rank_ff[i] <= rank_ff[i] + IW'(1);
               end
            end
         end
      end
   end

   // strobe result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_idx_ff <= r_idx;
         rsp_hit_ff <= r_hit;
         rsp_rd_ff  <= r_rd;
         rsp_cnt_ff <= r_cnt;
         rsp_st_ff  <= r_st;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_need_read    = rsp_rd_ff;
   assign rsp_refcount_now = rsp_cnt_ff;
   assign rsp_status       = rsp_st_ff;

   // every commit produces exactly one result word
   a_commit_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit without result strobe");

   // a miss that allocates always returns a fresh count of one
   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && wr_tag) |=> (rsp_refcount_now == 8'd1 && rsp_need_read))
      else $error("allocation result wrong");

   // the picked entry of a hit really matches the request tag
   a_hit_match: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && type_ff == REQ_GET && hit_ff && pick_found_ff) |->
      (tag_dev_ff[tgt] == dev_ff && tag_blk_ff[tgt] == blk_ff))
      else $error("hit on non-matching entry");

endmodule

FILE: rtl/core/lru_buffer_cache_core.sv
// ----------------------------------------------------------------------------
// lru_buffer_cache_core
// Buffer cache directory with LRU replacement: get, fill done, release,
// pin and unpin over a set of tagged, reference counted entries.
// ----------------------------------------------------------------------------
// Flow: an accepted request runs search, tree pick and commit in turn on the
// shared directory, and the result strobe is registered after commit. One
// request at a time: busy is high from accept until the end of commit.
// Reset: synchronous; all tags, valid bits and counts clear, ranks restart
// with entry 0 least recent. No clearing pass, requests are taken at once.
// The result strobe lasts one cycle; the receiver cannot stall it.
module lru_buffer_cache_core import lbc_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_device,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_entry_index,
   output logic        rsp_valid,
   output logic [4:0]  rsp_result_index,
   output logic        rsp_hit,
   output logic        rsp_need_read,
   output logic [7:0]  rsp_refcount_now,
   output logic [1:0]  rsp_status
);

   lbc_cmd_type cmd;

   lbc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lbc_datapath #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_device       (req_device),
      .req_block_number (req_block_number),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_result_index (rsp_result_index),
      .rsp_hit          (rsp_hit),
      .rsp_need_read    (rsp_need_read),
      .rsp_refcount_now (rsp_refcount_now),
      .rsp_status       (rsp_status)
   );

endmodule
